[rtl/core/tdpt_pkg.sv]
// Package for the trial-division prime test unit.
// Holds widths, candidate constants, controller states and the command/status structs.
// No dependencies.
package tdpt_pkg;

  // Width of the tested value and of the number port
  localparam int VALUE_WIDTH  = 32;
  localparam int NUMBER_WIDTH = 32;

  // Candidate i stays below 2^(VALUE_WIDTH/2) + CAND_STEP
  localparam int IDX_WIDTH = (VALUE_WIDTH + 1) / 2 + 2;
  // i*i tracked with headroom for the final overshoot
  localparam int SQ_WIDTH  = VALUE_WIDTH + 2;
  localparam int CNT_WIDTH = $clog2(VALUE_WIDTH + 1);

  localparam int FIRST_CAND = 5;
  localparam int CAND_STEP  = 6;
  localparam int RES_MOD    = 6;
  // (i+6)^2 - i^2 = 12*i + 36
  localparam int SQ_STEP_CONST = CAND_STEP * CAND_STEP;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD6,
    ST_TEST,
    ST_DIV,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;       // capture the number
    logic div_start;  // start both remainder units
    logic iter_init;  // i = 5, i*i = 25
    logic iter_step;  // i += 6, i*i updated
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic small_prime;  // two or three
    logic small_comp;   // one or four
    logic coprime6;     // n mod 6 is 1 or 5
    logic sq_gt_n;      // i*i > n, no divisor left to try
    logic div_lo_zero;
    logic div_hi_zero;
  } dp_status_t;

endpackage

[rtl/core/tdpt_divider.sv]
// Restoring remainder unit: one quotient bit per cycle.
// Depends on tdpt_pkg.
module tdpt_divider (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [tdpt_pkg::VALUE_WIDTH-1:0] dividend_i,
  input  logic [tdpt_pkg::VALUE_WIDTH-1:0] divisor_i,
  output logic                            busy_o,
  output logic [tdpt_pkg::VALUE_WIDTH-1:0] rem_o
);

  localparam int W  = tdpt_pkg::VALUE_WIDTH;
  localparam int CW = tdpt_pkg::CNT_WIDTH;

  logic          busy_q, busy_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  dvd_q, dvd_d;
  logic [W-1:0]  dvs_q, dvs_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // borrow out means the trial value was below the divisor
      rem_d = diff[W] ? trial[W-1:0] : diff[W-1:0];
      dvd_d = {dvd_q[W-2:0], 1'b0};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/tdpt_datapath.sv]
// Datapath: held number, candidate i, running i*i and two remainder units for i and i+2.
// Depends on tdpt_pkg and tdpt_divider.
module tdpt_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] number_i,
  input  tdpt_pkg::dp_cmd_t                cmd_i,
  output tdpt_pkg::dp_status_t             status_o
);

  localparam int W  = tdpt_pkg::VALUE_WIDTH;
  localparam int IW = tdpt_pkg::IDX_WIDTH;
  localparam int SW = tdpt_pkg::SQ_WIDTH;

  logic [W-1:0]  n_q, n_d;
  logic [IW-1:0] i_q, i_d;
  logic [SW-1:0] sq_q, sq_d;
  logic [W-1:0]  div_lo_dvs, div_hi_dvs;
  logic [W-1:0]  rem_lo, rem_hi;
  logic          busy_lo, busy_hi;

  // n mod 3 by folding: every even power of two is 1 mod 3, so halves add up
  function automatic logic [1:0] mod3(input logic [W-1:0] v);
    logic [63:0] x;
    logic [32:0] s1;
    logic [17:0] s2;
    logic [10:0] s3;
    logic [6:0]  s4;
    logic [4:0]  s5;
    logic [3:0]  s6;
    x  = 64'(v);
    s1 = {1'b0, x[63:32]} + {1'b0, x[31:0]};
    s2 = 18'(s1[32:16]) + 18'(s1[15:0]);
    s3 = 11'(s2[17:8]) + 11'(s2[7:0]);
    s4 = 7'(s3[10:6]) + 7'(s3[5:0]);
    s5 = 5'(s4[6:4]) + 5'(s4[3:0]);
    s6 = 4'(s5[4:2]) + 4'(s5[1:0]);
    if (s6 >= 4'd6) s6 = s6 - 4'd6;
    if (s6 >= 4'd3) s6 = s6 - 4'd3;
    return s6[1:0];
  endfunction

  always_comb begin
    n_d  = n_q;
    i_d  = i_q;
    sq_d = sq_q;
    if (cmd_i.load) begin
      n_d = W'(number_i);
    end
    if (cmd_i.iter_init) begin
      i_d  = IW'(tdpt_pkg::FIRST_CAND);
      sq_d = SW'(tdpt_pkg::FIRST_CAND * tdpt_pkg::FIRST_CAND);
    end else if (cmd_i.iter_step) begin
      i_d  = i_q + IW'(tdpt_pkg::CAND_STEP);
      sq_d = sq_q + SW'({i_q, 3'b000}) + SW'({i_q, 2'b00})
           + SW'(tdpt_pkg::SQ_STEP_CONST);
    end
  end

  always_ff @(posedge clk_i) begin
    n_q  <= n_d;
    i_q  <= i_d;
    sq_q <= sq_d;
  end

  assign div_lo_dvs = W'(i_q);
  assign div_hi_dvs = W'(i_q) + W'(2);

  tdpt_divider u_div_lo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q),
    .divisor_i  (div_lo_dvs),
    .busy_o     (busy_lo),
    .rem_o      (rem_lo)
  );

  tdpt_divider u_div_hi (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (n_q),
    .divisor_i  (div_hi_dvs),
    .busy_o     (busy_hi),
    .rem_o      (rem_hi)
  );

  always_comb begin
    status_o.div_busy    = busy_lo | busy_hi;
    status_o.small_prime = (n_q == W'(2)) || (n_q == W'(3));
    status_o.small_comp  = (n_q == W'(1)) || (n_q == W'(4));
    // odd and not a multiple of three
    status_o.coprime6    = n_q[0] && (mod3(n_q) != 2'd0);
    status_o.sq_gt_n     = sq_q > SW'(n_q);
    status_o.div_lo_zero = (rem_lo == '0);
    status_o.div_hi_zero = (rem_hi == '0);
  end

endmodule

[rtl/core/tdpt_ctrl.sv]
// Controller FSM: sequences the mod-6 screen and the candidate loop, holds the output register.
// Depends on tdpt_pkg.
module tdpt_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 is_prime_o,
  output tdpt_pkg::dp_cmd_t    cmd_o,
  input  tdpt_pkg::dp_status_t status_i
);

  tdpt_pkg::state_e state_q, state_d;
  logic res_q, res_d;
  logic out_valid_q, out_valid_d;
  logic is_prime_q, is_prime_d;
  logic out_load;

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      tdpt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tdpt_pkg::ST_MOD6;
        end
      end
      tdpt_pkg::ST_MOD6: begin
        if (status_i.small_prime) begin
          res_d   = 1'b1;
          state_d = tdpt_pkg::ST_FINISH;
        end else if (status_i.small_comp || !status_i.coprime6) begin
          res_d   = 1'b0;
          state_d = tdpt_pkg::ST_FINISH;
        end else begin
          cmd_o.iter_init = 1'b1;
          state_d         = tdpt_pkg::ST_TEST;
        end
      end
      tdpt_pkg::ST_TEST: begin
        if (status_i.sq_gt_n) begin
          res_d   = 1'b1;
          state_d = tdpt_pkg::ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = tdpt_pkg::ST_DIV;
        end
      end
      tdpt_pkg::ST_DIV: begin
        if (!status_i.div_busy) begin
          if (status_i.div_lo_zero || status_i.div_hi_zero) begin
            res_d   = 1'b0;
            state_d = tdpt_pkg::ST_FINISH;
          end else begin
            cmd_o.iter_step = 1'b1;
            state_d         = tdpt_pkg::ST_TEST;
          end
        end
      end
      tdpt_pkg::ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = tdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tdpt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    is_prime_d  = is_prime_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      is_prime_d  = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tdpt_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q      <= res_d;
    is_prime_q <= is_prime_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_prime_o  = is_prime_q;

endmodule

[rtl/core/trial_division_prime_test_unit.sv]
// Trial-division prime test unit: top level joining controller and datapath.
// Depends on tdpt_pkg, tdpt_ctrl, tdpt_datapath.
//
// Tests a 32-bit unsigned number for primality and returns one is_prime bit per number.
// One number is in flight at a time; the next is taken as soon as the result has been
// written to the output register, even if that result has not yet been transferred.
// From the input transfer to out_valid, with W = 32 value bits: numbers 0..4 and numbers
// screened out by the mod-6 test, which is combinational, go straight to the finish
// state; otherwise the unit tries the candidate pairs (i, i+2), i = 5, 11, 17, ...,
// until a divisor turns up or, for a prime, until i*i exceeds the number: up to about
// sqrt(n) / 6 pairs. Each pair costs one pass of the two bit-serial remainder units,
// which work on i and i+2 side by side, one bit per cycle, plus a check of the i*i
// bound. A stalled output adds its stall.
module trial_division_prime_test_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] number_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             is_prime_o
);

  tdpt_pkg::dp_cmd_t    cmd;
  tdpt_pkg::dp_status_t status;

  tdpt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_prime_o  (is_prime_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  tdpt_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .number_i (number_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

endmodule

[rtl/core/tdpt_checker.sv]
// Port-level checker for the trial-division prime test unit, bound to the top level.
// Depends on tdpt_pkg.
module tdpt_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic [tdpt_pkg::NUMBER_WIDTH-1:0] number_i,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             is_prime_o
);

  // a result waiting for transfer keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_prime_o))
    else $error("result dropped or changed while stalled");

  // one number at a time: busy right after taking one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a number is in flight");

  // a new result appears only as the unit goes back to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o && $past(!in_ready_o))
    else $error("result presented without a finished test");

  // an input transfer never coincides with a new result being written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result written in the cycle after an input transfer");

endmodule

bind trial_division_prime_test_unit tdpt_checker u_tdpt_checker (.*);

[test/prime_verdict_checker.sv]
// Checker for the trial-division prime test unit: watches both channels,
// predicts the prime/composite verdict of each number and compares results.
// Depends on tdpt_pkg for the value width and the candidate constants.
module prime_verdict_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [tdpt_pkg::NUMBER_WIDTH-1:0] number_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic                              is_prime_i,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic [tdpt_pkg::NUMBER_WIDTH-1:0] number;
    logic                              verdict;
  } verdict_entry_t;

  verdict_entry_t awaited_verdicts[$];
  verdict_entry_t head;
  int             mismatches = 0;

  // Trial division over 6k-1 / 6k+1 candidates, bound i <= n / i
  function automatic logic predict_primality(input logic [tdpt_pkg::NUMBER_WIDTH-1:0] raw);
    longint unsigned n;
    longint unsigned cand;
    longint unsigned mask;
    int              w;
    w = tdpt_pkg::VALUE_WIDTH;
    if (w < 1) w = 1;
    if (w > 64) w = 64;
    mask = ~64'd0 >> (64 - w);
    n = 64'(raw) & mask;
    if (n == 1 || n == 4) return 1'b0;
    if (n == 2 || n == 3) return 1'b1;
    if (n % tdpt_pkg::RES_MOD != 1 && n % tdpt_pkg::RES_MOD != 5) return 1'b0;
    for (cand = tdpt_pkg::FIRST_CAND; cand <= n / cand; cand += tdpt_pkg::CAND_STEP) begin
      if (n % cand == 0 || n % (cand + 2) == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      awaited_verdicts.delete();
      pending_o <= 0;
    end else begin
      // result side first: a number taken at this edge cannot answer at the same edge
      if (out_valid_i && out_ready_i) begin
        if (awaited_verdicts.size() == 0) begin
          report_mismatch($sformatf("result %b with no number outstanding", is_prime_i));
        end else begin
          head = awaited_verdicts.pop_front();
          if (is_prime_i !== head.verdict)
            report_mismatch($sformatf("number %0d: is_prime %b, predicted %b",
                                      head.number, is_prime_i, head.verdict));
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_verdicts.push_back({number_i, predict_primality(number_i)});
      pending_o    <= awaited_verdicts.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[test/trial_division_prime_test_unit_test.sv]
// Testbench top for the trial-division prime test unit: clock, reset, number stimulus
// with random idling on both channels, and the final verdict.
// Depends on tdpt_pkg, trial_division_prime_test_unit and prime_verdict_checker.
module trial_division_prime_test_unit_test;

  localparam int IDLE_PCT = 37;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [tdpt_pkg::NUMBER_WIDTH-1:0] number    = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic                              is_prime;
  logic                              steady    = 1'b0;
  int                                fail_count;
  int                                pending;

  trial_division_prime_test_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .number_i   (number),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .is_prime_o (is_prime)
  );

  prime_verdict_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .number_i    (number),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .is_prime_i  (is_prime),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else        out_ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
  end

  // one number per call; returns at the edge where the transfer happens
  task automatic send_number(input logic [tdpt_pkg::NUMBER_WIDTH-1:0] n);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    number   <= n;
    do @(posedge clk); while (!in_ready);
  endtask

  // Most numbers stay small: a prime near 2^32 needs the full candidate search
  function automatic logic [tdpt_pkg::NUMBER_WIDTH-1:0] random_number();
    logic [tdpt_pkg::NUMBER_WIDTH-1:0] n;
    int unsigned                       pick;
    int unsigned                       a;
    int unsigned                       b;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      n = $urandom_range(4095, 0);
    end else if (pick < 55) begin
      n = $urandom_range(262143, 0);
    end else if (pick < 70) begin
      a = $urandom_range(255, 2);
      b = ($urandom_range(3, 0) == 0) ? a : $urandom_range(255, 2);
      n = a * b;
    end else begin
      // full width, but with a factor below 32 so the search ends early
      a = $urandom_range(31, 2);
      n = $urandom;
      n = n - (n % a);
    end
    return n;
  endfunction

  logic [tdpt_pkg::NUMBER_WIDTH-1:0] directed_numbers[$] = '{
    32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd8, 32'd9,
    32'd25, 32'd35, 32'd49, 32'd121, 32'd143, 32'd169, 32'd289, 32'd323,
    32'd63001, 32'd65521, 32'd65537, 32'd2147483649, 32'd4294967294,
    32'd4294967295, 32'd4294967291
  };

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_numbers[k]) send_number(directed_numbers[k]);

    for (int k = 0; k < 75; k++) begin
      // stretch with no idling on either side
      if (k == 40) steady <= 1'b1;
      if (k == 70) steady <= 1'b0;
      send_number(random_number());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * tdpt_pkg::VALUE_WIDTH) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[trial_division_prime_test_unit.f]
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_divider.sv
rtl/core/tdpt_datapath.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test_unit.sv
rtl/core/tdpt_checker.sv
test/prime_verdict_checker.sv
test/trial_division_prime_test_unit_test.sv
